FILE: rtl/sem_pkg.sv
// Package for the Sobel edge magnitude block: column and channel column types,
// lane status struct, lane step codes and the sequencer state type.
// No dependencies.
package sem_pkg;

  // One column of three pixels: [row above/centre/below][channel r/g/b].
  // The packing matches the slave tdata layout exactly.
  typedef logic [2:0][2:0][7:0] column_t;

  // One channel of one column: [row above/centre/below].
  typedef logic [2:0][7:0] chan_col_t;

  typedef struct packed {
    logic busy;
    logic done;
  } lane_stat_t;

  // Lane step codes.
  localparam logic [3:0] SEM_STEP_SQUARE     = 4'd0;
  localparam logic [3:0] SEM_STEP_SUM        = 4'd1;
  localparam logic [3:0] SEM_STEP_ROOT_FIRST = 4'd2;
  localparam logic [3:0] SEM_STEP_ROOT_LAST  = 4'd9;
  localparam logic [3:0] SEM_STEP_ROUND      = 4'd10;

  localparam logic [7:0] SEM_MAG_MAX = 8'd255;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_CALC
  } seq_state_e;

endpackage

FILE: rtl/sem_lane.sv
// One channel lane: Sobel gradients, squared sum and a bit-serial rounded
// square root with saturation at 255. Depends on sem_pkg.
module sem_lane (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  sem_pkg::chan_col_t left_i,
  input  sem_pkg::chan_col_t mid_i,
  input  sem_pkg::chan_col_t right_i,
  output sem_pkg::lane_stat_t stat_o,
  output logic [7:0]         mag_o
);
  import sem_pkg::*;

  logic signed [11:0] gx_w, gy_w;
  logic signed [10:0] gx_q, gy_q;
  logic [19:0]        sqx_q, sqy_q;
  logic [20:0]        sum_q;
  logic [7:0]         root_q, root_d;
  logic [3:0]         step_q;
  logic               busy_q, done_q;
  logic [7:0]         mag_q;
  logic [2:0]         bit_idx;
  logic [7:0]         trial;
  logic [15:0]        trial_sq;
  logic [16:0]        round_lim;
  logic signed [21:0] prod_x, prod_y;

  function automatic logic signed [11:0] ext(input logic [7:0] v);
    ext = $signed({4'b0000, v});
  endfunction

  // Gx: right column minus left column, centre row weighted 2.
  // Gy: below row minus above row, centre column weighted 2.
  assign gx_w = ext(right_i[0]) + (ext(right_i[1]) <<< 1) + ext(right_i[2])
              - ext(left_i[0]) - (ext(left_i[1]) <<< 1) - ext(left_i[2]);
  assign gy_w = ext(left_i[2]) + (ext(mid_i[2]) <<< 1) + ext(right_i[2])
              - ext(left_i[0]) - (ext(mid_i[0]) <<< 1) - ext(right_i[0]);

  assign prod_x   = gx_q * gx_q;
  assign prod_y   = gy_q * gy_q;
  assign bit_idx  = 3'(step_q - SEM_STEP_ROOT_FIRST);
  assign trial    = root_q | (8'h80 >> bit_idx);
  assign trial_sq = trial * trial;
  assign round_lim = 17'(root_q * root_q) + 17'(root_q);

  always_comb begin
    root_d = root_q;
    if (trial_sq <= 16'(sum_q[15:0]) && sum_q[20:16] == 5'd0) begin
      root_d = trial;
    end else if (sum_q[20:16] != 5'd0) begin
      // Sum above 16 bits always clears the square of any 8-bit trial.
      root_d = trial;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= SEM_STEP_SQUARE;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= SEM_STEP_SQUARE;
    end else if (busy_q) begin
      if (step_q == SEM_STEP_ROUND) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        step_q <= step_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      gx_q   <= gx_w[10:0];
      gy_q   <= gy_w[10:0];
      root_q <= 8'd0;
    end else if (busy_q) begin
      if (step_q == SEM_STEP_SQUARE) begin
        sqx_q <= prod_x[19:0];
        sqy_q <= prod_y[19:0];
      end else if (step_q == SEM_STEP_SUM) begin
        sum_q <= 21'(sqx_q) + 21'(sqy_q);
      end else if (step_q >= SEM_STEP_ROOT_FIRST && step_q <= SEM_STEP_ROOT_LAST) begin
        root_q <= root_d;
      end else if (step_q == SEM_STEP_ROUND) begin
        if (root_q == SEM_MAG_MAX) begin
          mag_q <= SEM_MAG_MAX;
        end else if (sum_q > 21'(round_lim)) begin
          mag_q <= root_q + 8'd1;
        end else begin
          mag_q <= root_q;
        end
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign mag_o       = mag_q;

endmodule

FILE: rtl/sem_merge.sv
// Merging stage: collects the three lane magnitudes and the row end flag
// into the output register of the master stream. Depends on sem_pkg.
module sem_merge (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  logic [2:0][7:0]   mag_i,
  input  logic              row_end_i,
  output logic              free_o,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [23:0]       m_axis_tdata,   // edge_red, edge_green, edge_blue
  output logic              m_axis_tlast    // row_end
);
  import sem_pkg::*;

  logic        valid_q;
  logic [23:0] data_q;
  logic        last_q;

  assign free_o = !valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= {mag_i[2], mag_i[1], mag_i[0]};
      last_q <= row_end_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tlast  = last_q;

endmodule

FILE: rtl/sobel_edge_magnitude_rgb.sv
// Top level of the streaming RGB Sobel edge magnitude block.
// Depends on sem_pkg, sem_lane and sem_merge.

// Each slave transaction carries one image column of three vertically
// adjacent RGB pixels; tlast marks the rightmost column of a row. The block
// keeps the two previous columns and, per channel, returns
// round(sqrt(Gx^2 + Gy^2)) capped at 255 for the centre pixel of the middle
// column, with zero neighbours beyond the left and right row edges. The first
// column of a row gives no result unless it also closes the row; every later
// column gives one, and a last column that is not the first also flushes the
// final pixel of the row (master tlast set), so one column can give two
// results. A column that gives no result leaves the sequencer idle. A column
// that gives a result holds the slave side while the window is registered,
// the lanes are started, the eleven lane steps run (squares, their sum, an
// eight-step bit-serial square root and a rounding step) and the result is
// handed to the output register. The flush result at a row end runs the lanes
// again on the window shifted left; they restart from the handover of the
// first result. The three channel lanes share one sequencer. A handover waits
// while the output register is still full. The block works on one column at a
// time, but a finished result waits in the output register, so the next
// column can be taken while the master side stalls.
module sobel_edge_magnitude_rgb (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // above_red, above_green, above_blue, centre_red, centre_green,
  // centre_blue, below_red, below_green, below_blue
  input  logic [71:0] s_axis_tdata,
  input  logic        s_axis_tlast,   // last_in_row
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // edge_red, edge_green, edge_blue
  output logic        m_axis_tlast    // row_end
);
  import sem_pkg::*;

  seq_state_e state_q, state_d;

  // Row history: the two columns seen before the incoming one.
  column_t left_q, mid_q;
  logic    held_q;

  // Window that the lanes are working on, and what follows it.
  column_t win_left_q, win_mid_q, win_right_q;
  logic    row_end_q;
  logic    pend_b_q;
  logic    start_q, start_d;

  column_t    col;
  logic       accept;
  logic       launch;
  logic       load;
  logic       merge_free;
  lane_stat_t lane_stat [3];
  logic [2:0][7:0] lane_mag;

  assign col    = column_t'(s_axis_tdata);
  assign accept = s_axis_tvalid && s_axis_tready;
  // A column gives a result if a middle column is already held, or if it
  // both opens and closes a row.
  assign launch = held_q || s_axis_tlast;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SEQ_IDLE: begin
        if (accept && launch) begin
          state_d = SEQ_CALC;
        end
      end
      SEQ_CALC: begin
        if (load && !pend_b_q) begin
          state_d = SEQ_IDLE;
        end
      end
      default: state_d = SEQ_IDLE;
    endcase
  end

  // Outputs of the sequencer. The start pulse is registered at the same edge
  // as the window, so the lanes start on the new window; while it is high the
  // lanes' done flag still belongs to the previous window and is ignored.
  always_comb begin
    s_axis_tready = 1'b0;
    load          = 1'b0;
    start_d       = 1'b0;
    unique case (state_q)
      SEQ_IDLE: begin
        s_axis_tready = 1'b1;
        start_d       = accept && launch;
      end
      SEQ_CALC: begin
        load    = lane_stat[0].done && !start_q && merge_free;
        start_d = load && pend_b_q;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SEQ_IDLE;
      held_q   <= 1'b0;
      left_q   <= '0;
      mid_q    <= '0;
      pend_b_q <= 1'b0;
      start_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= start_d;
      if (accept) begin
        if (s_axis_tlast) begin
          // Row closes: history goes back to the empty row.
          left_q <= '0;
          mid_q  <= '0;
          held_q <= 1'b0;
        end else begin
          left_q <= held_q ? mid_q : column_t'('0);
          mid_q  <= col;
          held_q <= 1'b1;
        end
        pend_b_q <= held_q && s_axis_tlast;
      end else if (load) begin
        pend_b_q <= 1'b0;
      end
    end
  end

  // Window registers. The flush of the last pixel of a row reuses the window
  // just computed, shifted one column left with a zero right column.
  always_ff @(posedge clk_i) begin
    if (accept && launch) begin
      if (held_q) begin
        win_left_q  <= left_q;
        win_mid_q   <= mid_q;
        win_right_q <= col;
        row_end_q   <= 1'b0;
      end else begin
        win_left_q  <= '0;
        win_mid_q   <= col;
        win_right_q <= '0;
        row_end_q   <= 1'b1;
      end
    end else if (load && pend_b_q) begin
      win_left_q  <= win_mid_q;
      win_mid_q   <= win_right_q;
      win_right_q <= '0;
      row_end_q   <= 1'b1;
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_lane
    chan_col_t lane_left, lane_mid, lane_right;
    for (genvar p = 0; p < 3; p++) begin : g_row
      assign lane_left[p]  = win_left_q[p][c];
      assign lane_mid[p]   = win_mid_q[p][c];
      assign lane_right[p] = win_right_q[p][c];
    end
    sem_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (start_q),
      .left_i  (lane_left),
      .mid_i   (lane_mid),
      .right_i (lane_right),
      .stat_o  (lane_stat[c]),
      .mag_o   (lane_mag[c])
    );
  end

  sem_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .mag_i         (lane_mag),
    .row_end_i     (row_end_q),
    .free_o        (merge_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // The three lanes run in lockstep.
  a_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lane_stat[0] == lane_stat[1]) && (lane_stat[0] == lane_stat[2]))
    else $error("channel lanes out of step");

  // A result is taken from the lanes only when they have finished.
  a_load_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (lane_stat[0].done && !lane_stat[0].busy))
    else $error("result loaded from a busy lane");

  // A column that gives a result raises the lanes' start pulse in the next cycle.
  a_launch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && launch) |=> start_q)
    else $error("lanes not started after accepted column");

  // A pending row flush always follows an interior result.
  a_flush_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_b_q |-> !row_end_q)
    else $error("row flush pending behind a row end result");

endmodule

FILE: sim/tb_sobel_edge_magnitude_rgb.sv
// Self-checking testbench for sobel_edge_magnitude_rgb: column streams in,
// predicted per-channel Sobel magnitudes checked against every output.
// Depends on sem_pkg and the RTL of the block; needs nothing else.
module tb_sobel_edge_magnitude_rgb;
  import sem_pkg::*;

  localparam int CLK_PERIOD     = 20;
  localparam int RESET_CYCLES   = 7;
  localparam int TIMEOUT_CYCLES = 400000;
  localparam int DRAIN_LIMIT    = 20000;
  // Settling slack after the drain, with a margin over a column with two results.
  localparam int SETTLE_CYCLES  = 50;
  localparam int RANDOM_COLUMNS = 1600;

  // Content styles for generated columns.
  typedef enum int {
    FILL_ANY,     // every bit random
    FILL_TINY,    // values 0..7, so the rounding of small roots matters
    FILL_BINARY,  // each byte 0 or 255, the extremes
    FILL_SMOOTH   // values near mid-gray, small gradients
  } fill_e;

  // One output pixel: three channel magnitudes plus the row-end flag.
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       row_end;
  } edge_pix_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;

  sobel_edge_magnitude_rgb uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  // Window state of the predictor, updated on every accepted column.
  column_t   left_col;
  column_t   mid_col;
  bit        col_held;
  edge_pix_t pending_edges_q[$];

  int mismatches;
  int columns_sent;

  // Sender and receiver pacing knobs, changed by the test tasks.
  int gap_max;
  int burst_left;
  int stall_pct;
  int hold_left;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Rounded square root, capped: the r with r*r - r < s <= r*r + r.
  function automatic logic [7:0] rounded_root(int unsigned s);
    int unsigned r;
    int unsigned t;
    r = 0;
    for (int b = 128; b > 0; b = b >> 1) begin
      t = r | b;
      if (t * t <= s) r = t;
    end
    if (r >= 255) return SEM_MAG_MAX;
    if (s > r * r + r) r = r + 1;
    return 8'(r);
  endfunction

  // Gradient magnitude of all three channels for the centre of mc.
  function automatic logic [23:0] sobel_magnitude(column_t lc, column_t mc, column_t rc);
    int          gx;
    int          gy;
    int unsigned s;
    logic [23:0] mag;
    for (int c = 0; c < 3; c++) begin
      gx = int'(rc[0][c]) + 2 * int'(rc[1][c]) + int'(rc[2][c])
         - int'(lc[0][c]) - 2 * int'(lc[1][c]) - int'(lc[2][c]);
      gy = int'(lc[2][c]) + 2 * int'(mc[2][c]) + int'(rc[2][c])
         - int'(lc[0][c]) - 2 * int'(mc[0][c]) - int'(rc[0][c]);
      s = int'(gx * gx + gy * gy);
      mag[c*8 +: 8] = rounded_root(s);
    end
    return mag;
  endfunction

  // Advances the window by one accepted column and queues what it yields.
  function automatic void track_column(column_t col, bit last);
    if (col_held) begin
      pending_edges_q.push_back({sobel_magnitude(left_col, mid_col, col), 1'b0});
      left_col = mid_col;
      mid_col  = col;
    end else begin
      left_col = '0;
      mid_col  = col;
      col_held = 1'b1;
    end
    if (last) begin
      pending_edges_q.push_back({sobel_magnitude(left_col, mid_col, '0), 1'b1});
      left_col = '0;
      mid_col  = '0;
      col_held = 1'b0;
    end
  endfunction

  function automatic column_t random_column(fill_e fill);
    column_t col;
    for (int p = 0; p < 3; p++) begin
      for (int c = 0; c < 3; c++) begin
        case (fill)
          FILL_TINY:   col[p][c] = 8'($urandom_range(7));
          FILL_BINARY: col[p][c] = $urandom_range(1) ? 8'hFF : 8'h00;
          FILL_SMOOTH: col[p][c] = 8'($urandom_range(140, 100));
          default:     col[p][c] = 8'($urandom);
        endcase
      end
    end
    return col;
  endfunction

  function automatic column_t flat_column(logic [7:0] above, logic [7:0] centre,
                                          logic [7:0] below);
    column_t col;
    for (int c = 0; c < 3; c++) begin
      col[0][c] = above;
      col[1][c] = centre;
      col[2][c] = below;
    end
    return col;
  endfunction

  // Offers one column and returns once the block has taken it. Between
  // bursts of random length the sender drops tvalid for a random gap.
  task automatic send_column(column_t col, bit last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(12, 1);
      gap = (gap_max > 0) ? $urandom_range(gap_max) : 0;
      repeat (gap) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 72'({$urandom, $urandom, $urandom});
        s_axis_tlast  <= 1'($urandom);
      end
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= col;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    track_column(col, last);
    columns_sent++;
  endtask

  task automatic send_row(int len, fill_e fill);
    for (int i = 0; i < len; i++) send_column(random_column(fill), i == len - 1);
  endtask

  // Lets the block return everything queued so far, then some slack so that
  // nothing is still in flight.
  task automatic wait_results_done();
    int waited;
    waited = 0;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_edges_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // The receiver stalls at random with stall_pct percent, and holds off
  // completely while hold_left counts down.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else if (stall_pct == 0) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Every output transaction is compared with the oldest predicted pixel.
  always @(posedge clk_i) begin
    edge_pix_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_edges_q.size() == 0) begin
        $display("%0t: unexpected result data=%h last=%b", $time, m_axis_tdata,
                 m_axis_tlast);
        mismatches++;
      end else begin
        want = pending_edges_q.pop_front();
        if (m_axis_tdata[7:0] !== want.red) begin
          $display("%0t: red expected %0d actual %0d", $time, want.red,
                   m_axis_tdata[7:0]);
          mismatches++;
        end
        if (m_axis_tdata[15:8] !== want.green) begin
          $display("%0t: green expected %0d actual %0d", $time, want.green,
                   m_axis_tdata[15:8]);
          mismatches++;
        end
        if (m_axis_tdata[23:16] !== want.blue) begin
          $display("%0t: blue expected %0d actual %0d", $time, want.blue,
                   m_axis_tdata[23:16]);
          mismatches++;
        end
        if (m_axis_tlast !== want.row_end) begin
          $display("%0t: row_end expected %b actual %b", $time, want.row_end,
                   m_axis_tlast);
          mismatches++;
        end
      end
    end
  end

  // Extremes, single-column rows, flat areas and hard edges, with no idling.
  task automatic test_edge_cases();
    gap_max   = 0;
    stall_pct = 0;
    send_column(flat_column(8'd0, 8'd0, 8'd0), 1'b1);
    send_column(flat_column(8'd255, 8'd255, 8'd255), 1'b1);
    send_column(flat_column(8'd255, 8'd0, 8'd0), 1'b1);
    send_column(flat_column(8'd0, 8'd0, 8'd255), 1'b1);
    // Different small values per channel, so each lane is seen on its own.
    send_column(column_t'(72'h01_03_00_00_00_00_03_02_01), 1'b1);
    // Two-column row: the second column yields its own result and the flush.
    send_column(flat_column(8'd255, 8'd255, 8'd255), 1'b0);
    send_column(flat_column(8'd0, 8'd0, 8'd0), 1'b1);
    // Vertical step from black to white.
    send_column(flat_column(8'd0, 8'd0, 8'd0), 1'b0);
    send_column(flat_column(8'd0, 8'd0, 8'd0), 1'b0);
    send_column(flat_column(8'd255, 8'd255, 8'd255), 1'b1);
    // Flat white row: zero inside, saturated at both padded edges.
    for (int i = 0; i < 6; i++) send_column(flat_column(8'd255, 8'd255, 8'd255), i == 5);
    send_row(4, FILL_TINY);
    wait_results_done();
  endtask

  // Rows of random length and content under varying idle patterns.
  task automatic test_random_rows();
    int target;
    int len;
    fill_e fill;
    target = columns_sent + RANDOM_COLUMNS;
    while (columns_sent < target) begin
      case ($urandom_range(3))
        0: gap_max = 0;
        1: gap_max = 3;
        default: gap_max = 8;
      endcase
      case ($urandom_range(3))
        0: stall_pct = 0;
        1: stall_pct = 30;
        default: stall_pct = 70;
      endcase
      len = ($urandom_range(9) < 3) ? $urandom_range(3, 1) : $urandom_range(16, 4);
      fill = fill_e'($urandom_range(3));
      send_row(len, fill);
    end
    wait_results_done();
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering
  // columns, so the block backs up and drops s_axis_tready.
  task automatic test_output_hold();
    gap_max   = 0;
    stall_pct = 0;
    hold_left = 300;
    for (int i = 0; i < 8; i++) send_row(5, FILL_ANY);
    wait_results_done();
  endtask

  // The sender stops mid-stream until every result is back, then resumes
  // with the same row still open.
  task automatic test_sender_pause();
    gap_max   = 2;
    stall_pct = 30;
    send_column(random_column(FILL_ANY), 1'b0);
    send_column(random_column(FILL_ANY), 1'b0);
    wait_results_done();
    send_column(random_column(FILL_ANY), 1'b0);
    send_column(random_column(FILL_ANY), 1'b1);
    wait_results_done();
  endtask

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    left_col      = '0;
    mid_col       = '0;
    col_held      = 1'b0;
    mismatches    = 0;
    columns_sent  = 0;
    gap_max       = 0;
    burst_left    = 0;
    stall_pct     = 0;
    hold_left     = 0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    test_edge_cases();
    test_output_hold();
    test_sender_pause();
    test_random_rows();

    if (pending_edges_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time,
               pending_edges_q.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
